/* rtl/pidci_pkg.sv */
// ----------------------------------------------------------------------------
// pidci_pkg
// Shared types and constants of the clamped-integrator pid controller.
// ----------------------------------------------------------------------------
package pidci_pkg;

  // magnitude width of the p, i-increment and d terms, and their cap
  localparam int unsigned TERM_W = 60;
  localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};

  // output range and the largest sum that scales without overflow
  localparam logic signed [47:0] EFF_MAX  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] EFF_MIN  = 48'sh8000_0000_0000;
  localparam logic signed [47:0] EFF_SAFE = 48'sd140737488355;
  localparam logic [9:0]         ACT_FACTOR = 10'd1000;

  // sample period after reset, 0.004 s in q0.32
  localparam logic [31:0] PERIOD_RESET = 32'd17179869;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_GAIN_P = 3'd0,
    REG_GAIN_I = 3'd1,
    REG_GAIN_D = 3'd2,
    REG_LIMIT  = 3'd3,
    REG_PERIOD = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [30:0]        integ_limit;
    logic [31:0]        sample_period;
  } cfg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ADD,
    S_STORE,
    S_DIV,
    S_INTEG,
    S_SUM,
    S_OUT
  } state_t;

  // multiply-accumulate passes, in issue order
  typedef enum logic [2:0] {
    OP_P,
    OP_KIKP,
    OP_T,
    OP_E,
    OP_KPKD,
    OP_DIFF
  } op_t;

  typedef struct packed {
    logic       clear;
    logic       mul;
    logic       add;
    logic [1:0] limb;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // magnitude of a signed 32-bit value, two's complement minimum included
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

/* rtl/pidci_regs.sv */
// ----------------------------------------------------------------------------
// pidci_regs
// APB register file holding the gains, integrator limit and sample period.
// ----------------------------------------------------------------------------
module pidci_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output pidci_pkg::cfg_t  cfg
);
  import pidci_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p        <= '0;
      cfg.gain_i        <= '0;
      cfg.gain_d        <= '0;
      cfg.integ_limit   <= '0;
      cfg.sample_period <= PERIOD_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN_P: cfg.gain_p        <= pwdata;
        REG_GAIN_I: cfg.gain_i        <= pwdata;
        REG_GAIN_D: cfg.gain_d        <= pwdata;
        REG_LIMIT:  cfg.integ_limit   <= pwdata[30:0];
        REG_PERIOD: cfg.sample_period <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_GAIN_P: prdata = cfg.gain_p;
      REG_GAIN_I: prdata = cfg.gain_i;
      REG_GAIN_D: prdata = cfg.gain_d;
      REG_LIMIT:  prdata = {1'b0, cfg.integ_limit};
      REG_PERIOD: prdata = cfg.sample_period;
      default:    prdata = '0;
    endcase
  end

endmodule

/* rtl/pidci_mac.sv */
// ----------------------------------------------------------------------------
// pidci_mac
// Shared 32x32 multiplier with a registered product and a 128-bit
// accumulator that adds each product at a 32-bit limb offset.
// ----------------------------------------------------------------------------
module pidci_mac (
  input  logic                  clk,
  input  pidci_pkg::mac_ctrl_t  ctrl,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  output logic [127:0]          acc
);
  import pidci_pkg::*;

  logic [63:0]  prod;
  logic [127:0] addend;

  // product placed at its limb position
  assign addend = {64'b0, prod} << {ctrl.limb, 5'b0};

  // multiply, then accumulate on the following cycle
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= a * b;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add) begin
      acc <= acc + addend;
    end
  end

endmodule

/* rtl/pidci_div.sv */
// ----------------------------------------------------------------------------
// pidci_div
// Restoring divider for the derivative term, one quotient bit per cycle.
// Quotient saturates to the term cap; a zero divisor saturates as well, unless the numerator is zero.
// ----------------------------------------------------------------------------
module pidci_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              zero,
  input  logic [127:0]                      num,
  input  logic [31:0]                       den,
  output pidci_pkg::div_stat_t              stat,
  output logic [pidci_pkg::TERM_W-1:0]      quot
);
  import pidci_pkg::*;

  localparam int unsigned CNT_W = $clog2(TERM_W + 1);
  localparam int unsigned HI_W  = 128 - TERM_W;

  logic [HI_W-1:0]   hi;
  logic              ovf;
  logic [31:0]       rem;
  logic [TERM_W-1:0] shreg;
  logic [CNT_W-1:0]  count;
  logic [32:0]       r2;
  logic [32:0]       diff;
  logic              ge;

  // quotient overflows the cap when the upper part already reaches den
  assign hi  = num[127:TERM_W];
  assign ovf = (|hi[HI_W-1:32]) || (hi[31:0] >= den);

  // one restoring step
  assign r2   = {rem, shreg[TERM_W-1]};
  assign diff = r2 - {1'b0, den};
  assign ge   = r2 >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      count <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        if (zero || ovf) begin
          stat.done <= 1'b1;
        end else begin
          stat.busy <= 1'b1;
          count     <= CNT_W'(TERM_W);
        end
      end else if (stat.busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= hi[31:0];
      shreg <= num[TERM_W-1:0];
      if (zero) begin
        quot <= '0;
      end else if (ovf) begin
        quot <= TERM_MAX;
      end else begin
        quot <= '0;
      end
    end else if (stat.busy) begin
      rem   <= ge ? diff[31:0] : r2[31:0];
      shreg <= {shreg[TERM_W-2:0], 1'b0};
      quot  <= {quot[TERM_W-2:0], ge};
    end
  end

endmodule

/* rtl/pid_controller_clamped_integral.sv */
// ----------------------------------------------------------------------------
// pid_controller_clamped_integral
// One joint's pid loop with a clamped integrator, scaled by 1000 and
// saturated to 48 bits, signed fixed point with FRAC_BITS fraction bits.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   sample   | sample_valid, sample_ready, error_in     | in
//   result   | result_valid, result_ready, effort,      | out
//            | clipped                                  |
//   config   | psel, penable, pwrite, paddr, pwdata,    | in/out
//            | prdata, pready                           |
//
// One sample takes ten partial products of multiply-accumulate on the shared
// 32x32 unit, then the divider, which skips its iterations when the
// derivative is zero or saturates, then the integrator, sum and output
// steps.
// sample_ready is high only between samples; a finished result waits in
// the output register while the next sample is accepted.
// Synchronous reset clears the integrator, previous error, gains and limit.
// ----------------------------------------------------------------------------
module pid_controller_clamped_integral #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic signed [31:0] error_in,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [47:0] effort,
  output logic               clipped
);
  import pidci_pkg::*;

  localparam int unsigned INC_SHIFT = 2 * FRAC_BITS + 32;
  localparam int unsigned DIV_SHIFT = 2 * FRAC_BITS;
  localparam int unsigned STERM_W   = TERM_W + 1;
  localparam int unsigned S_W       = TERM_W + 2;
  localparam int unsigned SUM_W     = TERM_W + 3;

  cfg_t                     cfg;
  state_t                   state, state_next;
  op_t                      op;
  logic [1:0]               limb;
  logic [1:0]               last_limb;
  mac_ctrl_t                mac_ctrl;
  logic [31:0]              mac_a, mac_b;
  logic [127:0]             acc;
  logic                     div_start;
  div_stat_t                div_stat;
  logic [TERM_W-1:0]        d_mag;
  logic [127:0]             div_num;
  logic                     div_zero;

  logic [31:0]              mag_e, mag_diff;
  logic                     e_neg, diff_neg;
  logic signed [32:0]       diff_in;
  logic [95:0]              w;
  logic [TERM_W-1:0]        p_mag, inc_mag;
  logic [127:0]             p_shift, inc_shift;
  logic signed [31:0]       prev_error;
  logic signed [47:0]       integrator;
  logic signed [SUM_W-1:0]  sum;
  logic signed [STERM_W-1:0] p_term, inc_term, d_term;
  logic                     p_neg, inc_neg, d_neg;
  logic signed [S_W-1:0]    s_raw, s_clamp, lim_s;
  logic signed [47:0]       lim48;
  logic [47:0]              eff_scaled;
  logic                     out_free;

  // configuration registers
  pidci_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared multiply-accumulate unit
  pidci_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  // derivative divider, numerator is (kp*kd*diff) * 2^32 / 2^(2F)
  assign div_num  = {acc[95:0], 32'b0} >> DIV_SHIFT;
  assign div_zero = (acc[95:0] == 96'b0);

  pidci_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .zero  (div_zero),
    .num   (div_num),
    .den   (cfg.sample_period),
    .stat  (div_stat),
    .quot  (d_mag)
  );

  // operand selection for the current pass
  always_comb begin
    case (limb)
      2'd0:    mac_a = w[31:0];
      2'd1:    mac_a = w[63:32];
      default: mac_a = w[95:64];
    endcase
    case (op)
      OP_P:    mac_b = mag_e;
      OP_KIKP: mac_b = mag32(cfg.gain_p);
      OP_T:    mac_b = cfg.sample_period;
      OP_E:    mac_b = mag_e;
      OP_KPKD: mac_b = mag32(cfg.gain_d);
      OP_DIFF: mac_b = mag_diff;
      default: mac_b = '0;
    endcase
    case (op)
      OP_T, OP_DIFF: last_limb = 2'd1;
      OP_E:          last_limb = 2'd2;
      default:       last_limb = 2'd0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free     = !result_valid || result_ready;
  assign sample_ready = (state == S_IDLE);

  // next state and unit controls
  always_comb begin
    state_next = state;
    mac_ctrl   = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) state_next = S_LOAD;
      end
      S_LOAD: begin
        mac_ctrl.clear = 1'b1;
        state_next     = S_MUL;
      end
      S_MUL: begin
        mac_ctrl.mul = 1'b1;
        state_next   = S_ADD;
      end
      S_ADD: begin
        mac_ctrl.add  = 1'b1;
        mac_ctrl.limb = limb;
        state_next    = (limb == last_limb) ? S_STORE : S_MUL;
      end
      S_STORE: begin
        if (op == OP_DIFF) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_DIV: begin
        if (div_stat.done) state_next = S_INTEG;
      end
      S_INTEG: state_next = S_SUM;
      S_SUM:   state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // error difference at accept
  assign diff_in = 33'(error_in) - 33'(prev_error);

  // term extraction from the accumulator
  assign p_shift   = acc >> FRAC_BITS;
  assign inc_shift = acc >> INC_SHIFT;

  // signs of the terms
  assign p_neg   = cfg.gain_p[31] ^ e_neg;
  assign inc_neg = cfg.gain_i[31] ^ cfg.gain_p[31] ^ e_neg;
  assign d_neg   = cfg.gain_p[31] ^ cfg.gain_d[31] ^ diff_neg;

  assign p_term   = p_neg   ? -$signed({1'b0, p_mag})   : $signed({1'b0, p_mag});
  assign inc_term = inc_neg ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
  assign d_term   = d_neg   ? -$signed({1'b0, d_mag})   : $signed({1'b0, d_mag});

  // integrator step and clamp
  assign lim_s = S_W'($signed({1'b0, cfg.integ_limit}));
  assign lim48 = 48'($signed({1'b0, cfg.integ_limit}));
  assign s_raw = S_W'(integrator) + S_W'(inc_term);
  always_comb begin
    if (s_raw > lim_s) begin
      s_clamp = lim_s;
    end else if (s_raw < -lim_s) begin
      s_clamp = -lim_s;
    end else begin
      s_clamp = s_raw;
    end
  end

  // actuator scaling, only used when the sum is in the safe range
  assign eff_scaled = sum[47:0] * 48'(ACT_FACTOR);

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      integrator <= '0;
      op         <= OP_P;
      limb       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            mag_e      <= mag32(error_in);
            e_neg      <= error_in[31];
            mag_diff   <= diff_in[32] ? 32'(-diff_in) : diff_in[31:0];
            diff_neg   <= diff_in[32];
            prev_error <= error_in;
            op         <= OP_P;
          end
        end
        S_LOAD: begin
          limb <= '0;
          case (op)
            OP_P, OP_KPKD: w <= {64'b0, mag32(cfg.gain_p)};
            OP_KIKP:       w <= {64'b0, mag32(cfg.gain_i)};
            default: ;
          endcase
        end
        S_ADD: begin
          if (limb != last_limb) limb <= limb + 2'd1;
        end
        S_STORE: begin
          case (op)
            OP_P:    p_mag <= p_shift[TERM_W-1:0];
            OP_E: begin
              inc_mag <= (|inc_shift[127:TERM_W]) ? TERM_MAX : inc_shift[TERM_W-1:0];
            end
            OP_KIKP, OP_T, OP_KPKD: w <= acc[95:0];
            default: ;
          endcase
          case (op)
            OP_P:    op <= OP_KIKP;
            OP_KIKP: op <= OP_T;
            OP_T:    op <= OP_E;
            OP_E:    op <= OP_KPKD;
            OP_KPKD: op <= OP_DIFF;
            default: op <= OP_DIFF;
          endcase
        end
        S_INTEG: integrator <= 48'(s_clamp);
        S_SUM:   sum <= SUM_W'(p_term) + SUM_W'(integrator) + SUM_W'(d_term);
        default: ;
      endcase
    end
  end

  // output register, saturation of the scaled sum
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result_valid <= 1'b1;
      if (sum > SUM_W'(EFF_SAFE)) begin
        effort  <= EFF_MAX;
        clipped <= 1'b1;
      end else if (sum < -SUM_W'(EFF_SAFE)) begin
        effort  <= EFF_MIN;
        clipped <= 1'b1;
      end else begin
        effort  <= eff_scaled;
        clipped <= 1'b0;
      end
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // a saturated transaction carries one of the range limits
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && clipped |-> (effort == EFF_MAX || effort == EFF_MIN))
    else $error("clipped result not at a range limit");

  // integrator stays inside the clamp once updated
  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SUM |-> (integrator <= lim48 && integrator >= -lim48))
    else $error("integrator outside its limit");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider done outside the divide step");

  // divider is never restarted while iterating
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // one sample at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready && state == S_LOAD)
    else $error("sample accepted while another is in flight");

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clamped-integrator pid controller. Error
// samples go in over a valid/ready channel and the gains, integrator bound
// and sample period are loaded over the apb port between phases. A
// bit-accurate predictor computes effort and clipped for every accepted
// sample, and each returned result is checked against the oldest prediction.
// Directed samples cover error extremes, integrator clamping, term and output
// saturation, and the zero period. Random phases follow, with random gaps on
// both sides, one long result stall and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pidci_pkg::*;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned REG_STRIDE   = 4;
  localparam int unsigned NUM_REGS     = 5;
  localparam int unsigned LAST_IDX     = 7;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 94;
  localparam int unsigned MAX_MSGS     = 200;

  // one predicted result, with the sample that caused it
  typedef struct {
    logic signed [31:0] err;
    logic signed [47:0] effort;
    logic               clipped;
  } effort_t;

  // controller predictor and the queue of efforts still owed by the block
  class pid_tracker;
    cfg_t               cfg;
    logic signed [31:0] prev_err;
    longint             integ;
    effort_t            expected_q[$];
    int unsigned        fail_count;

    function new();
      cfg            = '0;
      cfg.sample_period = PERIOD_RESET;
      prev_err       = '0;
      integ          = 0;
      fail_count     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_GAIN_P: cfg.gain_p        = val;
        REG_GAIN_I: cfg.gain_i        = val;
        REG_GAIN_D: cfg.gain_d        = val;
        REG_LIMIT:  cfg.integ_limit   = val[30:0];
        REG_PERIOD: cfg.sample_period = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] mag(logic signed [31:0] v);
      return v[31] ? (32'd0 - v) : v;
    endfunction

    function logic [TERM_W-1:0] cap_term(logic [127:0] w);
      return (w > 128'(TERM_MAX)) ? TERM_MAX : w[TERM_W-1:0];
    endfunction

    function longint signed_term(logic [TERM_W-1:0] m, logic neg);
      longint v;
      v = longint'({4'b0, m});
      return neg ? -v : v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // predict the result of one accepted sample and advance the state
    function void take_sample(logic signed [31:0] e);
      logic [31:0]        me, mkp, mki, mkd;
      logic signed [32:0] diff;
      logic [32:0]        mdiff;
      logic [127:0]       w;
      logic [TERM_W-1:0]  dmag;
      longint             p, inc, d, s, sum, lim, safe, factor;
      effort_t            x;
      me    = mag(e);
      mkp   = mag(cfg.gain_p);
      mki   = mag(cfg.gain_i);
      mkd   = mag(cfg.gain_d);
      diff  = {e[31], e} - {prev_err[31], prev_err};
      mdiff = diff[32] ? (33'd0 - diff) : diff;

      // proportional term
      w = (128'(mkp) * 128'(me)) >> FRAC_BITS;
      p = signed_term(cap_term(w), cfg.gain_p[31] ^ e[31]);

      // integrator increment, then clamp
      w = (128'(mki) * 128'(mkp) * 128'(cfg.sample_period) * 128'(me))
          >> (2 * FRAC_BITS + 32);
      inc = signed_term(cap_term(w), cfg.gain_i[31] ^ cfg.gain_p[31] ^ e[31]);
      lim = longint'(cfg.integ_limit);
      s   = integ + inc;
      if (s > lim) s = lim;
      else if (s < -lim) s = -lim;

      // derivative term, saturated when the period is zero and the product is not
      w = (128'(mkp) * 128'(mkd) * 128'(mdiff)) << 32;
      if (cfg.sample_period == '0) begin
        dmag = (w == '0) ? '0 : TERM_MAX;
      end else begin
        dmag = cap_term((w / 128'(cfg.sample_period)) >> (2 * FRAC_BITS));
      end
      d = signed_term(dmag, cfg.gain_p[31] ^ cfg.gain_d[31] ^ diff[32]);

      // scale and saturate the output
      sum    = p + s + d;
      safe   = EFF_SAFE;
      factor = longint'(ACT_FACTOR);
      x.err  = e;
      if (sum > safe) begin
        x.effort  = EFF_MAX;
        x.clipped = 1'b1;
      end else if (sum < -safe) begin
        x.effort  = EFF_MIN;
        x.clipped = 1'b1;
      end else begin
        x.effort  = 48'(sum * factor);
        x.clipped = 1'b0;
      end
      expected_q.push_back(x);

      integ    = s;
      prev_err = e;
    endfunction

    task report_mismatch(string msg);
      if (fail_count < MAX_MSGS) $display("mismatch: %s", msg);
      fail_count++;
    endtask

    // compare one returned result with the oldest prediction
    task check_effort(logic signed [47:0] eff, logic clip);
      effort_t x;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result effort %0d clipped %0b", eff, clip));
        return;
      end
      x = expected_q.pop_front();
      if (eff !== x.effort)
        report_mismatch($sformatf("error %0d: effort %0d, predicted %0d",
                                  x.err, eff, x.effort));
      if (clip !== x.clipped)
        report_mismatch($sformatf("error %0d: clipped %0b, predicted %0b",
                                  x.err, clip, x.clipped));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               sample_valid;
  logic               sample_ready;
  logic signed [31:0] error_in;
  logic               result_valid;
  logic               result_ready;
  logic signed [47:0] effort;
  logic               clipped;

  pid_tracker book = new();

  int unsigned        tx_idle_pct = 20;
  int unsigned        rx_idle_pct = 5;
  bit                 hold_req    = 1'b0;
  logic signed [31:0] last_err    = '0;
  int unsigned        quiet_cycles = 0;

  pid_controller_clamped_integral #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .error_in     (error_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .effort       (effort),
    .clipped      (clipped)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transaction monitor: results are checked before the new sample is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) book.check_effort(effort, clipped);
      if (sample_valid && sample_ready) book.take_sample(error_in);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver: random stall bursts and one long hold-off on request
  initial begin : receiver
    int unsigned n;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        result_ready <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        n = $urandom_range(1, 19);
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // setup then access phase; psel stays up so writes can run back to back
  task automatic write_reg(int unsigned idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * REG_STRIDE);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_reg(reg_idx_t'(idx), val);
  endtask

  task automatic load_config(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                             logic [31:0] lim, logic [31:0] per, bit junk);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    if (junk) write_reg($urandom_range(NUM_REGS, LAST_IDX), $urandom);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_PERIOD, per);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one sample, at times after a random gap
  task automatic send_sample(logic signed [31:0] e);
    int unsigned gap;
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      gap = $urandom_range(1, 19);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    error_in     <= e;
    last_err      = e;
    do @(posedge clk); while (!sample_ready);
  endtask

  // stop offering and wait for every predicted result; the check runs only
  // after the monitor has seen the clock, so the last accepted sample is already noted
  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_error();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          3:       v = 32'sd1;
          default: v = -32'sd1;
        endcase
      end
      1, 2: v = $urandom;
      3, 4: v = last_err + $signed($urandom_range(0, 4096)) - 32'sd2048;
      5: begin
        v = $urandom_range(0, 1 << 26);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: begin
        v = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_gain();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0:    v = 32'sh7FFF_FFFF;
      1:    v = 32'sh8000_0000;
      2:    v = '0;
      3, 4: v = $urandom;
      default: begin
        v = $urandom_range(0, 1 << 19);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  // bit 31 is random at times; the block keeps only 31 bits
  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
      2, 3:    return $urandom;
      default: return $urandom_range(0, 1 << 22);
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return PERIOD_RESET;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_pct(bit rx);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return rx ? 3 : 10;
      2:       return rx ? 8 : 30;
      default: return rx ? 20 : 60;
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int unsigned ph, i;
    rst          = 1'b1;
    sample_valid = 1'b0;
    error_in     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // gains at reset: effort stays zero for error extremes
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    settle();

    // unit proportional gain and a small bound: integrator clamps high, then low
    load_config(32'h0001_0000, 32'h0064_0000, 32'h0000_028F, 32'h0000_8000,
                PERIOD_RESET, 1'b0);
    send_sample('0);
    send_sample(32'sd1);
    send_sample(-32'sd1);
    repeat (3) send_sample(32'sh0001_0000);
    repeat (3) send_sample(-32'sh0001_0000);
    settle();

    // extreme gains and period: terms and output saturate both ways
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b0);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
    send_sample(32'sd1);
    settle();

    // zero period: derivative is zero for a flat error, else saturated
    load_config(32'h0001_0000, '0, 32'hFFFF_0000, '0, '0, 1'b1);
    send_sample(32'sh0000_1234);
    send_sample(32'sh0000_1234);
    send_sample(32'sh0000_1235);
    send_sample(32'sh0000_1234);
    send_sample('0);
    settle();

    // random phases, each with its own settings and idle rates
    for (ph = 0; ph < PHASES; ph++) begin
      load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_period(),
                  $urandom_range(0, 3) == 0);
      if (ph == PHASES - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = pick_pct(1'b0);
        rx_idle_pct = pick_pct(1'b1);
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 10) hold_req = 1'b1;
        if (ph == 4 && i == 50) drain();
        send_sample(pick_error());
      end
      settle();
    end

    repeat (100) @(posedge clk);
    if (book.pending() != 0) book.report_mismatch("results missing at end of run");
    if (book.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
